[hw/rtl/dwslc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Dual-window sound level package
// Window sizes, derived widths, reciprocal constants and shared types.
// ----------------------------------------------------------------------------
package dwslc_pkg;

   localparam int LONG_WINDOW  = 255;
   localparam int SHORT_WINDOW = 10;
   localparam int SAMPLE_BITS  = 10;

   localparam int LONG_POS_BITS  = (LONG_WINDOW > 1) ? $clog2(LONG_WINDOW) : 1;
   localparam int SHORT_POS_BITS = (SHORT_WINDOW > 1) ? $clog2(SHORT_WINDOW) : 1;

   // A full window of maximum samples stays below WINDOW * 2**SAMPLE_BITS.
   localparam int LONG_SUM_BITS  = SAMPLE_BITS + $clog2(LONG_WINDOW);
   localparam int SHORT_SUM_BITS = SAMPLE_BITS + $clog2(SHORT_WINDOW);

   // The sum is divided by multiplying with ceil(2**SHIFT / WINDOW) and
   // keeping the bits above SHIFT. With SHIFT = SUM_BITS + ceil(log2 WINDOW)
   // the quotient is exact for every sum that fits in SUM_BITS.
   localparam int LONG_SHIFT       = LONG_SUM_BITS + $clog2(LONG_WINDOW);
   localparam int SHORT_SHIFT      = SHORT_SUM_BITS + $clog2(SHORT_WINDOW);
   localparam int LONG_RECIP_BITS  = LONG_SUM_BITS + 2;
   localparam int SHORT_RECIP_BITS = SHORT_SUM_BITS + 2;
   localparam int LONG_PROD_BITS   = LONG_SUM_BITS + LONG_RECIP_BITS;
   localparam int SHORT_PROD_BITS  = SHORT_SUM_BITS + SHORT_RECIP_BITS;

   localparam logic [63:0] LONG_RECIP_WIDE =
      ((64'd1 << LONG_SHIFT) + 64'(LONG_WINDOW - 1)) / 64'(LONG_WINDOW);
   localparam logic [63:0] SHORT_RECIP_WIDE =
      ((64'd1 << SHORT_SHIFT) + 64'(SHORT_WINDOW - 1)) / 64'(SHORT_WINDOW);
   localparam logic [LONG_RECIP_BITS-1:0] LONG_RECIP =
      LONG_RECIP_WIDE[LONG_RECIP_BITS-1:0];
   localparam logic [SHORT_RECIP_BITS-1:0] SHORT_RECIP =
      SHORT_RECIP_WIDE[SHORT_RECIP_BITS-1:0];

   typedef logic [SAMPLE_BITS-1:0]    sample_type;
   typedef logic [LONG_SUM_BITS-1:0]  long_sum_type;
   typedef logic [SHORT_SUM_BITS-1:0] short_sum_type;

   // Load enables of the three pipeline stages.
   typedef struct packed {
      logic load_s1;
      logic load_s2;
      logic load_out;
   } pipe_ctl_type;

   // A word after the ring stage: the new sample and the entries it replaces.
   typedef struct packed {
      sample_type sample;
      sample_type long_old;
      sample_type short_old;
   } stage1_type;

endpackage
`default_nettype wire

[hw/rtl/dual_window_sound_level_change.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Dual-window sound level change
// Long and short moving averages of a sensor stream and their difference.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake             Word
//   req_      in         req_valid/req_ready   sample
//   rsp_      out        rsp_valid/rsp_ready   long_average, short_average,
//                                              level_difference
//
// One word is accepted per cycle while no stalled result holds the stages;
// a result is presented once its word has passed three registers (ring read,
// sum update, reciprocal multiply).
// The long ring lives in a RAM whose single read and write ports set the rate.
// Reset clears sums and positions; unwritten long ring entries read as zero
// through a wrap flag, so no clearing pass is needed.
// A stalled result holds only the stages behind it that are full; free
// stages keep taking words.
// ----------------------------------------------------------------------------
module dual_window_sound_level_change import dwslc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire sample_type req_sample,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output sample_type      rsp_long_average,
   output sample_type      rsp_short_average,
   output sample_type      rsp_level_difference
);

   logic          s1_valid_ff;
   logic          s1_valid_in;
   logic          s2_valid_ff;
   logic          s2_valid_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          out_free;
   logic          s2_free;
   logic          s1_free;
   pipe_ctl_type  pipe_ctl;
   stage1_type    stage1_word;
   long_sum_type  long_sum;
   short_sum_type short_sum;

   // A stage is free when it is empty or its word moves on this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_free  = !s1_valid_ff || s2_free;

   always_comb begin
      pipe_ctl.load_s1  = req_valid && s1_free;
      pipe_ctl.load_s2  = s1_valid_ff && s2_free;
      pipe_ctl.load_out = s2_valid_ff && out_free;
   end

   assign s1_valid_in  = s1_free ? req_valid : s1_valid_ff;
   assign s2_valid_in  = s2_free ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = out_free ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = s1_free;
   assign rsp_valid = rsp_valid_ff;

   dwslc_ingest u_ingest (
      .clock       (clock),
      .reset       (reset),
      .pipe_ctl    (pipe_ctl),
      .req_sample  (req_sample),
      .stage1_word (stage1_word)
   );

   dwslc_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .pipe_ctl    (pipe_ctl),
      .stage1_word (stage1_word),
      .long_sum    (long_sum),
      .short_sum   (short_sum)
   );

   dwslc_scale u_scale (
      .clock                (clock),
      .pipe_ctl             (pipe_ctl),
      .long_sum             (long_sum),
      .short_sum            (short_sum),
      .rsp_long_average     (rsp_long_average),
      .rsp_short_average    (rsp_short_average),
      .rsp_level_difference (rsp_level_difference)
   );

`ifndef SYNTH
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      pipe_ctl.load_s1 |=> s1_valid_ff)
      else $error("accepted word did not reach the ring stage");

   a_stalled_sums_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !out_free) |=> ($stable(long_sum) && $stable(short_sum)))
      else $error("window sums changed while their word was stalled");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      pipe_ctl.load_out |=> rsp_valid_ff)
      else $error("loaded result not presented");
`endif

endmodule
`default_nettype wire

[hw/rtl/dwslc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read that returns the old
// contents when both ports hit the same address.
// ----------------------------------------------------------------------------
module dwslc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hw/rtl/dwslc_ingest.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Ring stage
// Writes each sample into both rings and fetches the entries it replaces.
// ----------------------------------------------------------------------------
module dwslc_ingest import dwslc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire pipe_ctl_type pipe_ctl,
   input  wire sample_type   req_sample,
   output stage1_type        stage1_word
);

   logic [LONG_POS_BITS-1:0]  long_pos_ff;
   logic [LONG_POS_BITS-1:0]  long_pos_in;
   logic [SHORT_POS_BITS-1:0] short_pos_ff;
   logic [SHORT_POS_BITS-1:0] short_pos_in;
   logic                      long_full_ff;
   logic                      long_full_in;
   logic                      long_wrap;
   logic                      short_wrap;
   sample_type                short_ring_ff [SHORT_WINDOW];
   sample_type                sample_ff;
   sample_type                short_old_ff;
   logic                      long_live_ff;
   sample_type                long_rd_data;

   assign long_wrap    = (long_pos_ff == LONG_POS_BITS'(LONG_WINDOW - 1));
   assign short_wrap   = (short_pos_ff == SHORT_POS_BITS'(SHORT_WINDOW - 1));
   assign long_pos_in  = long_wrap ? '0 : long_pos_ff + LONG_POS_BITS'(1);
   assign short_pos_in = short_wrap ? '0 : short_pos_ff + SHORT_POS_BITS'(1);

   // Writes walk the long ring in order, so the entry about to be replaced
   // has been written exactly when the ring has wrapped once.
   assign long_full_in = long_full_ff | long_wrap;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_pos_ff  <= '0;
         short_pos_ff <= '0;
         long_full_ff <= 1'b0;
         for (int i = 0; i < SHORT_WINDOW; i++) begin
            short_ring_ff[i] <= '0;
         end
      end else if (pipe_ctl.load_s1) begin
         long_pos_ff                 <= long_pos_in;
         short_pos_ff                <= short_pos_in;
         long_full_ff                <= long_full_in;
         short_ring_ff[short_pos_ff] <= req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_ctl.load_s1) begin
         sample_ff    <= req_sample;
         short_old_ff <= short_ring_ff[short_pos_ff];
         long_live_ff <= long_full_ff;
      end
   end

   dwslc_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(LONG_WINDOW)
   ) u_long_ring (
      .clock   (clock),
      .wr_en   (pipe_ctl.load_s1),
      .wr_addr (long_pos_ff),
      .wr_data (req_sample),
      .rd_en   (pipe_ctl.load_s1),
      .rd_addr (long_pos_ff),
      .rd_data (long_rd_data)
   );

   always_comb begin
      stage1_word.sample    = sample_ff;
      stage1_word.long_old  = long_live_ff ? long_rd_data : '0;
      stage1_word.short_old = short_old_ff;
   end

endmodule
`default_nettype wire

[hw/rtl/dwslc_accum.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Running sums
// Takes the replaced entry out of each window sum and adds the new sample.
// ----------------------------------------------------------------------------
module dwslc_accum import dwslc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire pipe_ctl_type pipe_ctl,
   input  wire stage1_type   stage1_word,
   output long_sum_type      long_sum,
   output short_sum_type     short_sum
);

   long_sum_type  long_sum_ff;
   long_sum_type  long_sum_in;
   short_sum_type short_sum_ff;
   short_sum_type short_sum_in;

   // The true sum always fits, so wrapping arithmetic gives it exactly.
   assign long_sum_in = long_sum_ff - LONG_SUM_BITS'(stage1_word.long_old)
                        + LONG_SUM_BITS'(stage1_word.sample);
   assign short_sum_in = short_sum_ff - SHORT_SUM_BITS'(stage1_word.short_old)
                         + SHORT_SUM_BITS'(stage1_word.sample);

   always_ff @(posedge clock) begin
      if (reset) begin
         long_sum_ff  <= '0;
         short_sum_ff <= '0;
      end else if (pipe_ctl.load_s2) begin
         long_sum_ff  <= long_sum_in;
         short_sum_ff <= short_sum_in;
      end
   end

   assign long_sum  = long_sum_ff;
   assign short_sum = short_sum_ff;

endmodule
`default_nettype wire

[hw/rtl/dwslc_scale.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Average stage
// Divides both sums by their window lengths and forms the level difference.
// ----------------------------------------------------------------------------
module dwslc_scale import dwslc_pkg::*; (
   input  wire logic          clock,
   input  wire pipe_ctl_type  pipe_ctl,
   input  wire long_sum_type  long_sum,
   input  wire short_sum_type short_sum,
   output sample_type         rsp_long_average,
   output sample_type         rsp_short_average,
   output sample_type         rsp_level_difference
);

   logic [LONG_PROD_BITS-1:0]  long_prod;
   logic [SHORT_PROD_BITS-1:0] short_prod;
   sample_type                 long_avg;
   sample_type                 short_avg;
   sample_type                 level_diff;
   sample_type                 long_average_ff;
   sample_type                 short_average_ff;
   sample_type                 level_difference_ff;

   assign long_prod  = LONG_PROD_BITS'(long_sum) * LONG_PROD_BITS'(LONG_RECIP);
   assign short_prod = SHORT_PROD_BITS'(short_sum) * SHORT_PROD_BITS'(SHORT_RECIP);
   assign long_avg   = long_prod[LONG_SHIFT +: SAMPLE_BITS];
   assign short_avg  = short_prod[SHORT_SHIFT +: SAMPLE_BITS];
   assign level_diff = (long_avg >= short_avg) ? (long_avg - short_avg)
                                               : (short_avg - long_avg);

   always_ff @(posedge clock) begin
      if (pipe_ctl.load_out) begin
         long_average_ff     <= long_avg;
         short_average_ff    <= short_avg;
         level_difference_ff <= level_diff;
      end
   end

   assign rsp_long_average     = long_average_ff;
   assign rsp_short_average    = short_average_ff;
   assign rsp_level_difference = level_difference_ff;

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-window sound level change testbench
// Streams sensor samples through the block and checks each result word
// against a long and short moving-average model kept in a scoreboard.
// ----------------------------------------------------------------------------
module tb;
   import dwslc_pkg::*;

   localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
   localparam int RANDOM_WORDS   = 800;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 8;

   class level_scoreboard;
      typedef struct {
         sample_type long_average;
         sample_type short_average;
         sample_type level_difference;
      } level_set_type;

      sample_type    long_ring[LONG_WINDOW];
      sample_type    short_ring[SHORT_WINDOW];
      long_sum_type  long_sum;
      short_sum_type short_sum;
      int unsigned   long_pos;
      int unsigned   short_pos;
      level_set_type expected_levels[$];
      int unsigned   samples_seen;
      int unsigned   results_checked;
      int unsigned   mismatch_count;
      int unsigned   peak_long;
      int unsigned   peak_difference;

      function new();
         foreach (long_ring[i]) long_ring[i] = '0;
         foreach (short_ring[i]) short_ring[i] = '0;
         long_sum        = '0;
         short_sum       = '0;
         long_pos        = 0;
         short_pos       = 0;
         samples_seen    = 0;
         results_checked = 0;
         mismatch_count  = 0;
         peak_long       = 0;
         peak_difference = 0;
      endfunction

      function int unsigned pending();
         return expected_levels.size();
      endfunction

      // Both rings start as zeros, so warm-up averages are divided by the
      // full window length like any other.
      function void note_sample(sample_type s);
         level_set_type lv;
         long_sum            = long_sum - long_ring[long_pos] + s;
         long_ring[long_pos] = s;
         long_pos            = (long_pos + 1 >= LONG_WINDOW) ? 0 : long_pos + 1;
         short_sum             = short_sum - short_ring[short_pos] + s;
         short_ring[short_pos] = s;
         short_pos             = (short_pos + 1 >= SHORT_WINDOW) ? 0 : short_pos + 1;
         lv.long_average  = sample_type'(long_sum / LONG_WINDOW);
         lv.short_average = sample_type'(short_sum / SHORT_WINDOW);
         lv.level_difference = (lv.long_average >= lv.short_average) ?
            lv.long_average - lv.short_average : lv.short_average - lv.long_average;
         expected_levels.push_back(lv);
         samples_seen++;
      endfunction

      function void flag(string what);
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
      endfunction

      function void check_result(sample_type la, sample_type sa, sample_type ld);
         level_set_type lv;
         if (expected_levels.size() == 0) begin
            flag($sformatf("result word with nothing expected (%0d %0d %0d)", la, sa, ld));
            return;
         end
         lv = expected_levels.pop_front();
         results_checked++;
         if (la != lv.long_average)
            flag($sformatf("word %0d long_average expected %0d actual %0d",
                           results_checked, lv.long_average, la));
         if (sa != lv.short_average)
            flag($sformatf("word %0d short_average expected %0d actual %0d",
                           results_checked, lv.short_average, sa));
         if (ld != lv.level_difference)
            flag($sformatf("word %0d level_difference expected %0d actual %0d",
                           results_checked, lv.level_difference, ld));
         if (la > peak_long) peak_long = la;
         if (ld > peak_difference) peak_difference = ld;
      endfunction
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_valid  = 1'b0;
   logic       req_ready;
   sample_type req_sample = '0;
   logic       rsp_valid;
   logic       rsp_ready  = 1'b0;
   sample_type rsp_long_average;
   sample_type rsp_short_average;
   sample_type rsp_level_difference;

   level_scoreboard sb;
   int burst_left   = 0;
   int words_sent   = 0;
   int idle_cycles  = 0;
   int stall_mode   = 0;
   int stall_left   = 0;
   int stall_cycle  = 0;

   dual_window_sound_level_change u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_sample           (req_sample),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_long_average     (rsp_long_average),
      .rsp_short_average    (rsp_short_average),
      .rsp_level_difference (rsp_level_difference)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Handshakes are sampled with the values that stood before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_long_average, rsp_short_average, rsp_level_difference);
         if (req_valid && req_ready)
            sb.note_sample(req_sample);
      end
   end

   // The receiver switches periodically between stall patterns.
   always @(posedge clock) begin
      stall_cycle++;
      if (stall_cycle % 100 == 0)
         stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 7) == 0)
                  stall_left = $urandom_range(1, 12);
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("FAIL dual_window_sound_level_change");
         $finish;
      end
   end

   // Words go out in bursts of random length separated by random gaps.
   task automatic send_word(input sample_type value);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic sample_type clamp_sample(input int value);
      if (value < 0) return '0;
      if (value > SAMPLE_MAX) return sample_type'(SAMPLE_MAX);
      return sample_type'(value);
   endfunction

   // One random stretch of the stream: noise, random flips between the rails,
   // a steady level with jitter, or a run at one rail.
   task automatic send_segment();
      int kind;
      int len;
      int level;
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 40);
      case (kind)
         3, 4: begin
            level = $urandom_range(0, SAMPLE_MAX);
            len   = $urandom_range(10, 60);
            repeat (len)
               send_word(clamp_sample(level + $urandom_range(0, 16) - 8));
         end
         5: begin
            level = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
            len   = $urandom_range(10, 120);
            repeat (len) send_word(sample_type'(level));
         end
         6: repeat (len)
               send_word($urandom_range(0, 1) ? sample_type'(SAMPLE_MAX) : '0);
         default: repeat (len)
               send_word(sample_type'($urandom_range(0, SAMPLE_MAX)));
      endcase
   endtask

   initial begin
      int target;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Warm-up from cleared rings, both rails, and every input bit.
      repeat (3) send_word(sample_type'(SAMPLE_MAX));
      send_word('0);
      send_word(sample_type'(1));
      send_word(sample_type'(SAMPLE_MAX - 1));
      send_word(sample_type'(512));
      for (int i = 0; i < SAMPLE_BITS; i++)
         send_word(sample_type'(1 << i));
      send_word('0);
      send_word(sample_type'(SAMPLE_MAX));
      drain_results();

      target = words_sent + RANDOM_WORDS;
      while (words_sent < target - 560) send_segment();

      // Fill the long window at full scale, then drop the short one to zero.
      drain_results();
      repeat (LONG_WINDOW + 5) send_word(sample_type'(SAMPLE_MAX));
      repeat (SHORT_WINDOW + 2) send_word('0);

      while (words_sent < target) send_segment();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d samples through warm-up, full-scale fill and random stretches;",
               words_sent);
      $display("checked %0d results, peak long average %0d, largest difference %0d.",
               sb.results_checked, sb.peak_long, sb.peak_difference);
      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("PASS dual_window_sound_level_change");
      end else begin
         $display("%0d mismatches", sb.mismatch_count);
         $display("FAIL dual_window_sound_level_change");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/dwslc_pkg.sv
hw/rtl/dwslc_ram.sv
hw/rtl/dwslc_ingest.sv
hw/rtl/dwslc_accum.sv
hw/rtl/dwslc_scale.sv
hw/rtl/dual_window_sound_level_change.sv
tb/tb.sv
